// ===== src/cbxt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbxt_pkg
// Types and codes shared by the counted binary xor trie block and its checker.
// ----------------------------------------------------------------------------
package cbxt_pkg;

    // action codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_ERASE  = 3'd1;
    localparam logic [2:0] ACT_MIN    = 3'd2;
    localparam logic [2:0] ACT_MAX    = 3'd3;
    localparam logic [2:0] ACT_COUNT  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam int CNT_BITS = 32;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] key;
        logic [31:0] bound;
    } t_in_item;

    typedef struct packed {
        logic [31:0] answer;
        logic [1:0]  status;
    } t_out_item;

endpackage

// ===== src/cbxt_node_mem.sv =====
// ----------------------------------------------------------------------------
// cbxt_node_mem
// Node pool: one write port and one registered read port. The root reads as
// zero until it is first written; a freshly allocated node reads as zero.
// ----------------------------------------------------------------------------
module cbxt_node_mem
    import cbxt_pkg::*;
#(
    parameter int NW    = 12,
    parameter int DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  logic [NW-1:0]     i_raddr,
    input  logic              i_rzero,
    input  logic              i_we,
    input  logic [NW-1:0]     i_waddr,
    input  logic [2*NW+CNT_BITS-1:0] i_wdata,
    output logic [2*NW+CNT_BITS-1:0] o_rdata
);

    localparam int DW = 2 * NW + CNT_BITS;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic          r_rzero;
    logic          r_root_ok;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // root valid bit and zero override for the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ok <= 1'b0;
            r_rzero   <= 1'b1;
        end else begin
            if (i_we && i_waddr == '0) begin
                r_root_ok <= 1'b1;
            end
            if (i_re) begin
                r_rzero <= i_rzero || (i_raddr == '0 && !r_root_ok);
            end
        end
    end

    assign o_rdata = r_rzero ? '0 : r_rdata;

endmodule

// ===== src/counted_binary_xor_trie_top.sv =====
// ----------------------------------------------------------------------------
// counted_binary_xor_trie_top
// A multiset of keys held as a counted binary trie in a node pool memory.
// Items insert, erase, or query min xor, max xor or the count of keys whose
// xor with the query key is below a bound. One item is worked at a time; the
// sequencer walks one trie level per step over the single memory read port.
// Insert and erase take two passes over the trie levels, the first to find or
// check the path and the second to update the counts; min/max xor visit a node
// and probe one or both children per bit, count visits a node and at most one
// counted child per bit, all ending in a result state. An exhausted pool reports status full.
// ----------------------------------------------------------------------------
module counted_binary_xor_trie_top
    import cbxt_pkg::*;
#(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int BW = $clog2(KEY_BITS);
    localparam int DW = 2 * NW + CNT_BITS;
    localparam int SW = NW + 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NODE  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CNT   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [2:0]          r_act, n_act;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_bound, n_bound;
    logic [BW-1:0]       r_bit, n_bit;
    logic                r_pass, n_pass;
    logic                r_leaf, n_leaf;
    logic                r_try, n_try;
    logic [NW-1:0]       r_cur, n_cur;
    logic [NW-1:0]       r_alt, n_alt;
    logic [BW:0]         r_need, n_need;
    logic [NW:0]         r_next_free, n_next_free;
    logic [31:0]         r_ans, n_ans;
    logic [1:0]          r_status, n_status;

    logic                mem_re, mem_rzero, mem_we;
    logic [NW-1:0]       mem_ra, mem_wa;
    logic [DW-1:0]       mem_wd, mem_rd;

    logic [CNT_BITS-1:0] nd_cnt;
    logic [NW-1:0]       nd_l0, nd_l1, link_p, link_np, lnk_a, lnk_o, fresh;
    logic                p, first, chosen, alloc;
    logic [63:0]         key64, bound64;
    logic [31:0]         bit_mask;
    logic [NW-1:0]       new_l0, new_l1;

    cbxt_node_mem #(.NW(NW), .DEPTH(NODE_COUNT)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (mem_re),
        .i_raddr (mem_ra),
        .i_rzero (mem_rzero),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    // node decode and per-bit terms
    assign nd_cnt   = mem_rd[CNT_BITS-1:0];
    assign nd_l0    = mem_rd[NW+CNT_BITS-1:CNT_BITS];
    assign nd_l1    = mem_rd[2*NW+CNT_BITS-1:NW+CNT_BITS];
    assign p        = r_key[r_bit];
    assign link_p   = p ? nd_l1 : nd_l0;
    assign link_np  = p ? nd_l0 : nd_l1;
    assign first    = p ^ (r_act == ACT_MAX);
    assign lnk_a    = first ? nd_l1 : nd_l0;
    assign lnk_o    = first ? nd_l0 : nd_l1;
    assign chosen   = r_try ? !first : first;
    assign fresh    = r_next_free[NW-1:0];
    assign alloc    = !r_leaf && link_p == '0;
    assign new_l0   = (alloc && !p) ? fresh : nd_l0;
    assign new_l1   = (alloc && p) ? fresh : nd_l1;
    assign bit_mask = 32'(64'd1 << r_bit);
    assign key64    = {32'd0, i_in.key};
    assign bound64  = {32'd0, i_in.bound};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_key       = r_key;
        n_bound     = r_bound;
        n_bit       = r_bit;
        n_pass      = r_pass;
        n_leaf      = r_leaf;
        n_try       = r_try;
        n_cur       = r_cur;
        n_alt       = r_alt;
        n_need      = r_need;
        n_next_free = r_next_free;
        n_ans       = r_ans;
        n_status    = r_status;
        mem_re      = 1'b0;
        mem_ra      = '0;
        mem_rzero   = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_cur;
        mem_wd      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in.action;
                    n_key    = key64[KEY_BITS-1:0];
                    n_bound  = bound64[KEY_BITS-1:0];
                    n_ans    = '0;
                    n_status = ST_OK;
                    n_pass   = 1'b0;
                    n_leaf   = 1'b0;
                    n_cur    = '0;
                    n_bit    = BW'(KEY_BITS - 1);
                    if (i_in.action > ACT_COUNT) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_NODE;
                    end
                end
            end

            S_CHK: begin
                if (SW'(r_next_free) + SW'(r_need) > SW'(NODE_COUNT)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_pass  = 1'b1;
                    n_leaf  = 1'b0;
                    n_cur   = '0;
                    n_bit   = BW'(KEY_BITS - 1);
                    n_state = S_NODE;
                end
            end

            S_NODE: begin
                priority if (r_act == ACT_INSERT && !r_pass) begin
                    // find how many new nodes the key needs
                    if (link_p == '0) begin
                        n_need  = (BW+1)'(r_bit) + 1'b1;
                        n_state = S_CHK;
                    end else if (r_bit == '0) begin
                        n_need  = '0;
                        n_state = S_CHK;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = link_p;
                        n_cur  = link_p;
                        n_bit  = r_bit - 1'b1;
                    end
                end else if (r_act == ACT_INSERT) begin
                    // bump count, hook a new child where missing
                    mem_we = 1'b1;
                    mem_wd = {new_l1, new_l0, nd_cnt + 1'b1};
                    if (r_leaf) begin
                        n_state = S_DONE;
                    end else begin
                        if (alloc) begin
                            n_next_free = r_next_free + 1'b1;
                        end
                        mem_re    = 1'b1;
                        mem_rzero = alloc;
                        mem_ra    = alloc ? fresh : link_p;
                        n_cur     = alloc ? fresh : link_p;
                        if (r_bit == '0) n_leaf = 1'b1;
                        else             n_bit  = r_bit - 1'b1;
                    end
                end else if (r_act == ACT_ERASE && !r_pass) begin
                    // confirm the key is present
                    if (r_leaf) begin
                        if (nd_cnt == '0) begin
                            n_status = ST_ABSENT;
                            n_state  = S_DONE;
                        end else begin
                            mem_re = 1'b1;
                            n_pass = 1'b1;
                            n_leaf = 1'b0;
                            n_cur  = '0;
                            n_bit  = BW'(KEY_BITS - 1);
                        end
                    end else if (link_p == '0) begin
                        n_status = ST_ABSENT;
                        n_state  = S_DONE;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = link_p;
                        n_cur  = link_p;
                        if (r_bit == '0) n_leaf = 1'b1;
                        else             n_bit  = r_bit - 1'b1;
                    end
                end else if (r_act == ACT_ERASE) begin
                    // drop one count along the path
                    mem_we = 1'b1;
                    mem_wd = {nd_l1, nd_l0, nd_cnt - 1'b1};
                    if (r_leaf) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = link_p;
                        n_cur  = link_p;
                        if (r_bit == '0) n_leaf = 1'b1;
                        else             n_bit  = r_bit - 1'b1;
                    end
                end else if (!r_pass && nd_cnt == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end else if (r_act == ACT_COUNT) begin
                    // count keys below the bound at this level
                    n_pass = 1'b1;
                    if (r_bound[r_bit]) begin
                        n_alt = link_np;
                        if (link_p != '0) begin
                            mem_re  = 1'b1;
                            mem_ra  = link_p;
                            n_state = S_CNT;
                        end else if (link_np == '0 || r_bit == '0) begin
                            n_state = S_DONE;
                        end else begin
                            mem_re = 1'b1;
                            mem_ra = link_np;
                            n_bit  = r_bit - 1'b1;
                        end
                    end else if (link_p == '0 || r_bit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = link_p;
                        n_bit  = r_bit - 1'b1;
                    end
                end else begin
                    // min or max xor: probe the preferred child first
                    n_pass = 1'b1;
                    n_alt  = lnk_o;
                    if (lnk_a != '0) begin
                        mem_re  = 1'b1;
                        mem_ra  = lnk_a;
                        n_try   = 1'b0;
                        n_state = S_PROBE;
                    end else if (lnk_o != '0) begin
                        mem_re  = 1'b1;
                        mem_ra  = lnk_o;
                        n_try   = 1'b1;
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_PROBE: begin
                if (nd_cnt != '0) begin
                    if (chosen != p) n_ans = r_ans | bit_mask;
                    if (r_bit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_NODE;
                    end
                end else if (!r_try && r_alt != '0) begin
                    mem_re = 1'b1;
                    mem_ra = r_alt;
                    n_try  = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_CNT: begin
                n_ans = r_ans + nd_cnt;
                if (r_alt == '0 || r_bit == '0) begin
                    n_state = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_alt;
                    n_bit   = r_bit - 1'b1;
                    n_state = S_NODE;
                end
            end

            S_DONE: begin
                if (i_out_ready) n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= (NW+1)'(1);
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_key    <= n_key;
        r_bound  <= n_bound;
        r_bit    <= n_bit;
        r_pass   <= n_pass;
        r_leaf   <= n_leaf;
        r_try    <= n_try;
        r_cur    <= n_cur;
        r_alt    <= n_alt;
        r_need   <= n_need;
        r_ans    <= n_ans;
        r_status <= n_status;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_DONE);
    assign o_out.answer  = r_ans;
    assign o_out.status  = r_status;

endmodule

// ===== src/cbxt_checker.sv =====
// ----------------------------------------------------------------------------
// cbxt_checker
// Port-level checks for the counted binary xor trie block.
// ----------------------------------------------------------------------------
module cbxt_checker
    import cbxt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // nothing to show right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one item at a time: busy once an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting an item");

    // never open for input while a result waits
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("ready while a result is pending");

    // failed items carry a zero answer
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> o_out.answer == '0)
        else $error("nonzero answer on failed item");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

endmodule

bind counted_binary_xor_trie_top cbxt_checker u_cbxt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
